FILE: sv/mrm_pkg.sv
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared constants, word table and helper functions for the modem response
// matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package mrm_pkg;

    localparam int WORD_COUNT   = 6;
    localparam int MAX_WORD_LEN = 12;

    // Table size for the word text and lengths; slots past the six words are
    // empty (length zero) and never match.
    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int PROG_W     = 4;
    localparam int CODE_W     = 3;
    localparam int BYTE_W     = 8;
    localparam int TEXT_W     = SLOT_COUNT * BYTE_W;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [PROG_W-1:0] prog_t;
    typedef logic [CODE_W-1:0] code_t;

    // Response codes
    localparam code_t CODE_OK         = 3'd0;
    localparam code_t CODE_READY      = 3'd1;
    localparam code_t CODE_ERROR      = 3'd2;
    localparam code_t CODE_RING       = 3'd3;
    localparam code_t CODE_NO_CARRIER = 3'd4;
    localparam code_t CODE_UNLINK     = 3'd5;

    // Word text, first character in the most significant byte.
    localparam logic [TEXT_W-1:0] WORD_TEXT [SLOT_COUNT] = '{
        {"OK",           {14{8'h00}}},
        {"+CPIN: READY", { 4{8'h00}}},
        {"ERROR",        {11{8'h00}}},
        {"RING",         {12{8'h00}}},
        {"NO CARRIER",   { 6{8'h00}}},
        {"Unlink",       {10{8'h00}}},
        {TEXT_W{1'b0}}, {TEXT_W{1'b0}}, {TEXT_W{1'b0}}, {TEXT_W{1'b0}},
        {TEXT_W{1'b0}}, {TEXT_W{1'b0}}, {TEXT_W{1'b0}}, {TEXT_W{1'b0}},
        {TEXT_W{1'b0}}, {TEXT_W{1'b0}}
    };

    localparam prog_t WORD_LEN [SLOT_COUNT] = '{
        4'd2, 4'd12, 4'd5, 4'd4, 4'd10, 4'd6,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
    };

    localparam prog_t MAX_LEN_CLIP = prog_t'((MAX_WORD_LEN > 15) ? 15 : MAX_WORD_LEN);

    // Effective length: only the first MAX_WORD_LEN characters must match.
    function automatic prog_t eff_len(input logic [SLOT_W-1:0] w);
        prog_t n;
        n = WORD_LEN[w];
        if (n > MAX_LEN_CLIP)
        begin
            n = MAX_LEN_CLIP;
        end
        return n;
    endfunction

    // Expected character at position p of word w.
    function automatic byte_t word_char(input logic [SLOT_W-1:0] w, input prog_t p);
        logic [TEXT_W-1:0] txt;
        txt = WORD_TEXT[w];
        return txt[TEXT_W-1-BYTE_W*int'(p) -: BYTE_W];
    endfunction

endpackage

`default_nettype wire

FILE: sv/modem_response_matcher.sv
// ----------------------------------------------------------------------------
// modem_response_matcher
// Scans received serial bytes for fixed modem response words and reports a
// match code on the byte that completes a word.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+-------------------------------
//  input    | in_valid  / in_stall    | rx_byte[7:0]
//  output   | out_valid / out_stall   | found, response_code[2:0]
//
//  Rate: one byte per clock while out_stall stays low. A transfer lands in
//  the input register; once a queue slot is free, all word counters update
//  in parallel and the result is written into a two-entry output queue.
//  Reset: rst_n clears the counters and all valid flags; no clearing pass.
//  Stalls: the output queue absorbs one extra result, so the input keeps
//  taking bytes while a result waits; in_stall rises only when both queue
//  entries are full, out_stall holds the front entry and the input register
//  holds a byte.
//
`default_nettype none

module modem_response_matcher
    import mrm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              in_valid,
    output      logic              in_stall,
    input  wire logic [BYTE_W-1:0] rx_byte,

    output      logic              out_valid,
    input  wire logic              out_stall,
    output      logic              found,
    output      logic [CODE_W-1:0] response_code
);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic  in_vld_reg, in_vld_next;
    byte_t byte_reg,   byte_next;

    // Per-word progress counters
    prog_t progress_reg  [WORD_COUNT];
    prog_t progress_next [WORD_COUNT];

    // Two-entry result queue; entry 0 drives the output ports
    logic [1:0] q_vld_reg, q_vld_next;
    logic       q_found_reg [2];
    logic       q_found_next[2];
    code_t      q_code_reg  [2];
    code_t      q_code_next [2];

    logic  pop;
    logic  advance;
    logic  accept;

    // Result of the byte held in the input register
    logic  hit;
    code_t hit_code;
    prog_t step_prog [WORD_COUNT];

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign pop       = q_vld_reg[0] & ~out_stall;
    // Advance the input register into the queue when a slot is free.
    assign advance   = in_vld_reg & (~q_vld_reg[1] | pop);
    assign in_stall  = in_vld_reg & ~advance;
    assign accept    = in_valid & ~in_stall;

    assign out_valid     = q_vld_reg[0];
    assign found         = q_found_reg[0];
    assign response_code = q_code_reg[0];

    // ------------------------------------------------------------------
    // Word compare: every counter steps in parallel on the held byte
    // ------------------------------------------------------------------
    always_comb
    begin
        logic  done;
        prog_t n;
        prog_t p;
        hit      = 1'b0;
        hit_code = CODE_OK;
        for (int w = 0; w < WORD_COUNT; w++)
        begin
            n    = eff_len(SLOT_W'(w));
            p    = progress_reg[w];
            done = 1'b0;
            if ((n == '0) || (p >= n))
            begin
                // Empty slot or out-of-range counter: drop to zero.
                step_prog[w] = '0;
            end
            else if (word_char(SLOT_W'(w), p) == byte_reg)
            begin
                step_prog[w] = p + prog_t'(1);
                done         = ((p + prog_t'(1)) == n);
            end
            else
            begin
                // Mismatch: restart, the byte is not retried as a first char.
                step_prog[w] = '0;
            end
            // Later words override earlier ones: highest index wins.
            if (done)
            begin
                hit      = 1'b1;
                hit_code = code_t'(w);
            end
        end
    end

    always_comb
    begin
        for (int w = 0; w < WORD_COUNT; w++)
        begin
            if (!advance)
            begin
                progress_next[w] = progress_reg[w];
            end
            else if (hit)
            begin
                // A match clears every counter.
                progress_next[w] = '0;
            end
            else
            begin
                progress_next[w] = step_prog[w];
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register next state
    // ------------------------------------------------------------------
    always_comb
    begin
        in_vld_next = in_vld_reg;
        byte_next   = byte_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
            byte_next   = rx_byte;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result queue next state: shift on pop, then push into first free slot
    // ------------------------------------------------------------------
    always_comb
    begin
        q_vld_next      = q_vld_reg;
        q_found_next[0] = q_found_reg[0];
        q_found_next[1] = q_found_reg[1];
        q_code_next[0]  = q_code_reg[0];
        q_code_next[1]  = q_code_reg[1];
        if (pop)
        begin
            q_vld_next[0]   = q_vld_reg[1];
            q_vld_next[1]   = 1'b0;
            q_found_next[0] = q_found_reg[1];
            q_code_next[0]  = q_code_reg[1];
        end
        if (advance)
        begin
            if (!q_vld_next[0])
            begin
                q_vld_next[0]   = 1'b1;
                q_found_next[0] = hit;
                q_code_next[0]  = hit ? hit_code : CODE_OK;
            end
            else
            begin
                q_vld_next[1]   = 1'b1;
                q_found_next[1] = hit;
                q_code_next[1]  = hit ? hit_code : CODE_OK;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            q_vld_reg  <= '0;
            for (int w = 0; w < WORD_COUNT; w++)
            begin
                progress_reg[w] <= '0;
            end
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            q_vld_reg  <= q_vld_next;
            for (int w = 0; w < WORD_COUNT; w++)
            begin
                progress_reg[w] <= progress_next[w];
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        q_found_reg[0] <= q_found_next[0];
        q_found_reg[1] <= q_found_next[1];
        q_code_reg[0]  <= q_code_next[0];
        q_code_reg[1]  <= q_code_next[1];
    end

endmodule

`default_nettype wire

FILE: sv/mrm_checker.sv
// ----------------------------------------------------------------------------
// mrm_assertions
// Port-level assertions for the modem response matcher, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mrm_assertions
    import mrm_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic              found,
    input wire logic [CODE_W-1:0] response_code
);

    // Reset drops every result: out_valid is low right after any edge that sees reset low.
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("out_valid high after reset");

    // A non-match result carries code zero.
    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (response_code == CODE_OK))
        else $error("response_code nonzero without found");

    // Only the six defined words can match.
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (response_code <= CODE_UNLINK))
        else $error("response_code out of range");

    // Input backpressure only when results are waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall with no pending result");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(found) && $stable(response_code)))
        else $error("stalled result changed");

endmodule

bind modem_response_matcher mrm_assertions u_mrm_assertions (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .response_code (response_code)
);

`default_nettype wire
